/* rtl/bps_pkg.sv */
// Shared types, constants and helper functions for the binomial particle splitter.
`default_nettype none

package bps_pkg;

  localparam int WordW   = 32;
  localparam int CellW   = 31;
  localparam int CountW  = 4;
  localparam int StepW   = 5;
  localparam int CoefW   = 4;
  localparam int ShiftW  = 3;
  localparam int CfgSelW = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 31;
  localparam int NumW    = 5;   // holds a child count of up to 16
  localparam int WProdW  = WordW + CoefW;
  localparam int OffW    = WordW + StepW;

  // children emitted per mother at most; the count itself never exceeds 16
  localparam int MaxChildrenDef = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CELL_WIDTH = 2'd0,
    CFG_REFINE     = 2'd1,
    CFG_ORDER      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        [WordW-1:0] mother_weight;
    logic signed [WordW-1:0] mother_position;
    logic signed [WordW-1:0] velocity_x;
    logic signed [WordW-1:0] velocity_y;
    logic signed [WordW-1:0] velocity_z;
  } mother_t;

  typedef struct packed {
    logic        [WordW-1:0]  child_weight;
    logic signed [WordW-1:0]  child_position;
    logic signed [WordW-1:0]  child_velocity_x;
    logic signed [WordW-1:0]  child_velocity_y;
    logic signed [WordW-1:0]  child_velocity_z;
    logic        [CountW-1:0] child_number;
    logic                     last_child;
  } child_t;

  // one child slot handed from the sequencer to the arithmetic pipeline
  typedef struct packed {
    logic        [WordW-1:0]  weight;
    logic        [WordW-1:0]  position;
    logic        [WordW-1:0]  vel_x;
    logic        [WordW-1:0]  vel_y;
    logic        [WordW-1:0]  vel_z;
    logic        [CountW-1:0] k;
    logic        [CoefW-1:0]  coef;
    logic signed [StepW-1:0]  step;
    logic                     last;
    logic        [ShiftW-1:0] shift;
  } slot_t;

  localparam logic [CoefW-1:0] BinomTab [6][6] = '{
    '{4'd1, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0},
    '{4'd1, 4'd1, 4'd0,  4'd0,  4'd0, 4'd0},
    '{4'd1, 4'd2, 4'd1,  4'd0,  4'd0, 4'd0},
    '{4'd1, 4'd3, 4'd3,  4'd1,  4'd0, 4'd0},
    '{4'd1, 4'd4, 4'd6,  4'd4,  4'd1, 4'd0},
    '{4'd1, 4'd5, 4'd10, 4'd10, 4'd5, 4'd1}
  };

  // zero reads as one, anything above four saturates
  function automatic logic [CfgSelW-1:0] clamp14(input logic [CfgSelW-1:0] v);
    logic [CfgSelW-1:0] r;
    r = v;
    if (v == 3'd0) r = 3'd1;
    else if (v > 3'd4) r = 3'd4;
    return r;
  endfunction

  // C(row, k); zero beyond the end of the row
  function automatic logic [CoefW-1:0] binom_coef(input logic [CfgSelW-1:0] row,
                                                  input logic [CountW-1:0] k);
    logic [CoefW-1:0] c;
    c = '0;
    if (row <= 3'd5 && k <= {1'b0, row}) c = BinomTab[row][k[2:0]];
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/bps_stream_if.sv */
// Valid/ready stream interface carrying one payload item per handshake.
`default_nettype none

interface bps_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/binomial_particle_splitter.sv */
// Binomial particle splitter: each mother item becomes (r-1)(p+1)+1 child items.
//
// Channels: mother_i (sink) takes one mother particle per valid/ready
// handshake; child_o (source) gives one child per handshake, in order
// k = 0..n-1, with last_child set on the final one. The configuration
// port (cfg_we_i, cfg_idx_i, cfg_data_i) writes cell width, refine factor
// and interpolation order, one register per write; write only while the block is idle.
// The first child of a mother is valid once the mother has passed the
// sequencer's holding register and the pipeline stages. Throughput: one
// child per cycle unless the receiver stalls; a mother gives n =
// (r-1)(p+1)+1 children (1 to 16, capped at MaxChildren), issued by the
// sequencer one slot per cycle; the next mother is taken in the cycle its
// predecessor's last child is issued, so mothers follow with no gap.
// Reset clears the pipeline valid bits and the sequencer and loads the
// configuration defaults (dx = 1.0, r = 2, p = 1). When the receiver stalls
// the whole pipeline and the sequencer hold; no child is lost or repeated.
`default_nettype none

module binomial_particle_splitter
  import bps_pkg::*;
#(
  parameter int MaxChildren = MaxChildrenDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  bps_stream_if.sink              mother_i,
  bps_stream_if.source            child_o
);

  logic [CellW-1:0]   cell_width_q;
  logic [CfgSelW-1:0] refine_q, order_q;

  logic  advance;
  logic  slot_valid;
  slot_t slot;
  logic  out_valid;
  child_t out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_width_q <= CellW'(65536);
      refine_q     <= 3'd2;
      order_q      <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CELL_WIDTH: cell_width_q <= cfg_data_i[CellW-1:0];
        CFG_REFINE:     refine_q     <= cfg_data_i[CfgSelW-1:0];
        CFG_ORDER:      order_q      <= cfg_data_i[CfgSelW-1:0];
        default: ;
      endcase
    end
  end

  bps_sequencer #(
    .MaxChildren (MaxChildren)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (mother_i.valid),
    .in_ready_o   (mother_i.ready),
    .in_data_i    (mother_i.payload),
    .refine_i     (refine_q),
    .order_i      (order_q),
    .advance_i    (advance),
    .slot_valid_o (slot_valid),
    .slot_o       (slot)
  );

  bps_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_width_i (cell_width_q),
    .slot_valid_i (slot_valid),
    .slot_i       (slot),
    .advance_o    (advance),
    .out_valid_o  (out_valid),
    .out_ready_i  (child_o.ready),
    .out_data_o   (out_data)
  );

  assign child_o.valid   = out_valid;
  assign child_o.payload = out_data;

endmodule

`default_nettype wire

/* rtl/bps_sequencer.sv */
// Mother holding register and child sequencer issuing one child slot per cycle unless stalled.
`default_nettype none

module bps_sequencer
  import bps_pkg::*;
#(
  parameter int MaxChildren = MaxChildrenDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mother_t            in_data_i,
  input  wire logic [CfgSelW-1:0] refine_i,
  input  wire logic [CfgSelW-1:0] order_i,
  input  wire logic               advance_i,
  output logic                    slot_valid_o,
  output slot_t                   slot_o
);

  logic [CfgSelW-1:0] r_c, p_c, row_c;
  logic [NumW-1:0]    n_c, nm1_c, emit_c, em1_c;
  logic [ShiftW-1:0]  shift_c;
  logic               is_last_c, accept_c;
  logic signed [StepW:0] step_c;

  logic              busy_q;
  logic [CountW-1:0] k_q;
  mother_t           mother_q;

  always_comb begin
    r_c     = clamp14(refine_i);
    p_c     = clamp14(order_i);
    row_c   = p_c + 3'd1;
    n_c     = NumW'(({2'b00, r_c} - 5'd1) * {2'b00, row_c} + 5'd1);
    nm1_c   = n_c - 5'd1;
    // only the first MaxChildren children go out
    if (int'(n_c) > MaxChildren) emit_c = NumW'(MaxChildren);
    else emit_c = n_c;
    em1_c   = emit_c - 5'd1;
    shift_c = (r_c >= 3'd2) ? row_c : '0;
    is_last_c = ({1'b0, k_q} == em1_c);
    // offset multiplier 2k - (n-1), always within -15..15
    step_c  = $signed({1'b0, k_q, 1'b0}) - $signed({1'b0, nm1_c});
  end

  assign in_ready_o = !busy_q || (advance_i && is_last_c);
  assign accept_c   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (accept_c) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (busy_q && advance_i) begin
      if (is_last_c) busy_q <= 1'b0;
      else k_q <= k_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_c) mother_q <= in_data_i;
  end

  always_comb begin
    slot_valid_o    = busy_q;
    slot_o.weight   = mother_q.mother_weight;
    slot_o.position = mother_q.mother_position;
    slot_o.vel_x    = mother_q.velocity_x;
    slot_o.vel_y    = mother_q.velocity_y;
    slot_o.vel_z    = mother_q.velocity_z;
    slot_o.k        = k_q;
    slot_o.coef     = binom_coef(row_c, k_q);
    slot_o.step     = step_c[StepW-1:0];
    slot_o.last     = is_last_c;
    slot_o.shift    = shift_c;
  end

`ifndef SYNTH
  a_accept_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_c && busy_q) |-> (advance_i && is_last_c))
    else $error("new mother taken before the last child was issued");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ({1'b0, k_q} < emit_c))
    else $error("child index beyond child count");

  a_k_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && advance_i && !is_last_c) |=> (busy_q && k_q == $past(k_q) + 4'd1))
    else $error("child index skipped or repeated");
`endif

endmodule

`default_nettype wire

/* rtl/bps_datapath.sv */
// Three-stage arithmetic pipeline: weight and offset products, then shift and add.
`default_nettype none

module bps_datapath
  import bps_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CellW-1:0] cell_width_i,
  input  wire logic             slot_valid_i,
  input  wire slot_t            slot_i,
  output logic                  advance_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output child_t                out_data_o
);

  logic en_c;

  logic   v1_q, v2_q, v3_q;
  slot_t  s1_q;

  logic        [WProdW-1:0] wprod_q;
  logic signed [OffW-1:0]   off_q;
  logic        [WordW-1:0]  pos2_q, vx2_q, vy2_q, vz2_q;
  logic        [CountW-1:0] k2_q;
  logic                     last2_q;
  logic        [ShiftW-1:0] shift2_q;

  child_t s3_q;

  logic signed [OffW-1:0] step_x_c, dx_x_c, off_c;
  logic        [WProdW-1:0] wprod_c, wshift_c;

  // the whole pipeline moves together whenever the output slot is free
  assign en_c      = !v3_q || out_ready_i;
  assign advance_o = en_c;

  always_comb begin
    step_x_c = {{(OffW-StepW){s1_q.step[StepW-1]}}, s1_q.step};
    dx_x_c   = {{(OffW-CellW){1'b0}}, cell_width_i};
    off_c    = step_x_c * dx_x_c;
    wprod_c  = {{WordW{1'b0}}, s1_q.coef} * {{CoefW{1'b0}}, s1_q.weight};
    wshift_c = wprod_q >> shift2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_c) begin
      v1_q <= slot_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      s1_q <= slot_i;

      wprod_q  <= wprod_c;
      off_q    <= off_c;
      pos2_q   <= s1_q.position;
      vx2_q    <= s1_q.vel_x;
      vy2_q    <= s1_q.vel_y;
      vz2_q    <= s1_q.vel_z;
      k2_q     <= s1_q.k;
      last2_q  <= s1_q.last;
      shift2_q <= s1_q.shift;

      s3_q.child_weight     <= wshift_c[WordW-1:0];
      // halving with floor, then a wrapping add
      s3_q.child_position   <= pos2_q + off_q[WordW:1];
      s3_q.child_velocity_x <= vx2_q;
      s3_q.child_velocity_y <= vy2_q;
      s3_q.child_velocity_z <= vz2_q;
      s3_q.child_number     <= k2_q;
      s3_q.last_child       <= last2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_c |=> ({v1_q, v2_q, v3_q} == $past({v1_q, v2_q, v3_q})))
    else $error("pipeline moved while stalled");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_c && v2_q) |=> v3_q)
    else $error("item lost between second and output stage");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("waiting child changed or dropped");
`endif

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the binomial particle splitter: mothers in, predicted children out.
`default_nettype none

module tb_top;
  import bps_pkg::*;

  localparam int HalfPeriod  = 10;
  localparam int ResetCycles = 8;
  localparam int IdleLimit   = 5000;
  localparam int TailCycles  = 16;
  localparam int ChildCap    = 16;
  localparam int RandPhases  = 10;
  localparam int PhaseItems  = 35;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgW-1:0]     cfg_data;

  bps_stream_if #(.payload_t(mother_t)) mother_if ();
  bps_stream_if #(.payload_t(child_t))  child_if ();

  binomial_particle_splitter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .mother_i   (mother_if),
    .child_o    (child_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // predictor's copy of the registers
  logic [CfgW-1:0] dx_cfg;
  logic [2:0]      refine_cfg;
  logic [2:0]      order_cfg;

  child_t children_due[$];
  int     errors;
  int     quiet_cycles;
  int     stall_left;
  bit     stall_en;
  bit     gap_en;

  function automatic int unsigned binom(int unsigned m, int unsigned k);
    int unsigned c;
    c = 1;
    if (k > m) return 0;
    for (int unsigned i = 0; i < k; i++) c = c * (m - i) / (i + 1);
    return c;
  endfunction

  function automatic int unsigned clamp_sel(logic [2:0] v);
    if (v == 3'd0) return 1;
    if (v > 3'd4) return 4;
    return 32'(v);
  endfunction

  // expected children of one accepted mother under the current registers
  function automatic void split_mother(mother_t m);
    int unsigned r, p, n, emit, shift, c;
    longint      step, off;
    logic [63:0] wp;
    child_t      ch;
    r     = clamp_sel(refine_cfg);
    p     = clamp_sel(order_cfg);
    n     = (r - 1) * (p + 1) + 1;
    shift = (r >= 2) ? p + 1 : 0;
    emit  = (n > ChildCap) ? ChildCap : n;
    for (int unsigned k = 0; k < emit; k++) begin
      c    = binom(p + 1, k);
      wp   = {32'b0, m.mother_weight} * 64'(c);
      step = 2 * longint'(k) - (longint'(n) - 1);
      off  = (step * longint'({33'b0, dx_cfg})) >>> 1;   // floor of half
      ch.child_weight     = 32'(wp >> shift);
      ch.child_position   = m.mother_position + off[31:0];
      ch.child_velocity_x = m.velocity_x;
      ch.child_velocity_y = m.velocity_y;
      ch.child_velocity_z = m.velocity_z;
      ch.child_number     = k[CountW-1:0];
      ch.last_child       = (k + 1 == emit);
      children_due.insert(children_due.size(), ch);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // prediction first, so a child can never overtake its own mother's expectation
  always @(posedge clk_i) begin
    child_t want;
    if (rst_ni) begin
      if (mother_if.valid && mother_if.ready) split_mother(mother_if.payload);
      if (child_if.valid && child_if.ready) begin
        if (children_due.size() == 0) begin
          errors++;
          $display("%0t: child with none due, expected none actual k=%0d", $time,
                   child_if.payload.child_number);
        end else begin
          want = children_due.pop_front();
          check_field("child_weight", want.child_weight, child_if.payload.child_weight);
          check_field("child_position", want.child_position,
                      child_if.payload.child_position);
          check_field("child_velocity_x", want.child_velocity_x,
                      child_if.payload.child_velocity_x);
          check_field("child_velocity_y", want.child_velocity_y,
                      child_if.payload.child_velocity_y);
          check_field("child_velocity_z", want.child_velocity_z,
                      child_if.payload.child_velocity_z);
          check_field("child_number", 32'(want.child_number),
                      32'(child_if.payload.child_number));
          check_field("last_child", 32'(want.last_child), 32'(child_if.payload.last_child));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((mother_if.valid && mother_if.ready) || (child_if.valid && child_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      child_if.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (stall_en && $urandom_range(0, 3) == 0) begin
      child_if.ready <= 1'b0;
      stall_left     <= pick_gap() - 1;
    end else begin
      child_if.ready <= 1'b1;
    end
  end

  function automatic int send_gap();
    if (!gap_en || $urandom_range(0, 9) < 6) return 0;
    return pick_gap();
  endfunction

  // valid stays high between back-to-back items
  task automatic send_mother(mother_t m);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      mother_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mother_if.valid   <= 1'b1;
    mother_if.payload <= m;
    @(posedge clk_i);
    while (!mother_if.ready) @(posedge clk_i);
  endtask

  task automatic settle_block();
    mother_if.valid <= 1'b0;
    @(posedge clk_i);
    while (children_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // three writes on consecutive edges; only called while idle
  task automatic set_config(logic [CfgW-1:0] dx, logic [CfgW-1:0] rdata,
                            logic [CfgW-1:0] pdata);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_CELL_WIDTH;
    cfg_data <= dx;
    @(posedge clk_i);
    dx_cfg   = dx;
    cfg_idx  <= CFG_REFINE;
    cfg_data <= rdata;
    @(posedge clk_i);
    refine_cfg = rdata[2:0];
    cfg_idx  <= CFG_ORDER;
    cfg_data <= pdata;
    @(posedge clk_i);
    order_cfg = pdata[2:0];
    cfg_we   <= 1'b0;
  endtask

  function automatic mother_t make_mother(logic [31:0] w, logic [31:0] x, logic [31:0] vx,
                                          logic [31:0] vy, logic [31:0] vz);
    mother_t m;
    m.mother_weight   = w;
    m.mother_position = x;
    m.velocity_x      = vx;
    m.velocity_y      = vy;
    m.velocity_z      = vz;
    return m;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CfgW-1:0] rand_cell();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {CfgW{1'b1}};
      2:       return CfgW'(65536);
      3:       return CfgW'($urandom_range(0, 255));
      default: return v[CfgW-1:0];
    endcase
  endfunction

  // mostly in range, sometimes the clamped codes; upper bits are junk
  function automatic logic [CfgW-1:0] rand_sel();
    logic [31:0] junk;
    logic [2:0]  v;
    junk = $urandom;
    if ($urandom_range(0, 9) < 7) v = 3'($urandom_range(1, 4));
    else v = 3'($urandom_range(0, 7));
    return {junk[CfgW-4:0], v};
  endfunction

  task automatic test_default_config();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    send_mother(make_mother(32'h0001_0000, 32'h0000_0000, 32'h0000_1000, 32'hFFFF_F000,
                            32'h0000_0001));
    send_mother(make_mother(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF));
    send_mother(make_mother(32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h0000_0000));
    settle_block();
  endtask

  task automatic test_field_extremes();
    // sixteen children and the widest cell: positions wrap both ways
    set_config({CfgW{1'b1}}, CfgW'(4), CfgW'(4));
    send_mother(make_mother(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h0F0F_0F0F));
    send_mother(make_mother(32'h0000_0001, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hF0F0_F0F0));
    send_mother(make_mother(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                            32'h0000_0000));
    settle_block();
    // zero cell width and a refine factor of one: a single copy of the mother
    set_config('0, CfgW'(1), CfgW'(1));
    send_mother(make_mother(32'hFFFF_FFFF, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF));
    send_mother(make_mother(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFE,
                            32'h7FFF_FFFF));
    settle_block();
    // codes of zero read as one
    set_config(CfgW'(65536), {28'hFFFFFFF, 3'd0}, {28'h0000001, 3'd0});
    send_mother(make_mother(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000,
                            32'h0000_0000));
    send_mother(make_mother(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000));
    settle_block();
    // codes above four saturate, zero cell width puts every child on the mother
    set_config('0, CfgW'(7), CfgW'(7));
    send_mother(make_mother(32'hFFFF_FFFF, 32'h8000_0000, 32'hDEAD_BEEF, 32'h0BAD_F00D,
                            32'hCAFE_0001));
    send_mother(make_mother(32'h0000_0003, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                            32'h0000_0000));
    settle_block();
    // more children than coefficients: the tail gets zero weight
    set_config(CfgW'(32'h0003_0000), CfgW'(3), CfgW'(2));
    send_mother(make_mother(32'hFFFF_FFFF, 32'h0000_0000, 32'h1111_1111, 32'h2222_2222,
                            32'h3333_3333));
    send_mother(make_mother(32'h0000_0007, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
    settle_block();
    set_config(CfgW'(5), CfgW'(5), CfgW'(6));
    send_mother(make_mother(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE,
                            32'h0000_8000));
    settle_block();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < RandPhases; ph++) begin
      // some phases run flat out on both sides
      gap_en   = ($urandom_range(0, 3) != 0);
      stall_en = ($urandom_range(0, 3) != 0);
      if (ph == 0) set_config({CfgW{1'b1}}, CfgW'(4), CfgW'(4));
      else set_config(rand_cell(), rand_sel(), rand_sel());
      for (int i = 0; i < PhaseItems; i++)
        send_mother(make_mother(rand_word(), rand_word(), rand_word(), rand_word(),
                                rand_word()));
      settle_block();
    end
  endtask

  initial begin
    errors            = 0;
    quiet_cycles      = 0;
    stall_left        = 0;
    stall_en          = 1'b0;
    gap_en            = 1'b0;
    dx_cfg            = CfgW'(65536);
    refine_cfg        = 3'd2;
    order_cfg         = 3'd1;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_CELL_WIDTH;
    cfg_data          = '0;
    mother_if.valid   = 1'b0;
    mother_if.payload = '0;
    child_if.ready    = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_config();
    test_field_extremes();
    test_random_traffic();

    settle_block();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/bps_pkg.sv
rtl/bps_stream_if.sv
rtl/bps_sequencer.sv
rtl/bps_datapath.sv
rtl/binomial_particle_splitter.sv
test/tb_top.sv
